@@ hw/rtl/ept_pkg.sv @@
// Shared types and constants for the ellipse point pipeline.
// Used by ept_horner_cell, ept_sqrt_cell and ellipse_point_at_angle.
package ept_pkg;

  // Q30 fixed point for angles, sine and cosine
  localparam int unsigned FRAC_BITS = 30;
  localparam int unsigned ANG_W = 30;
  localparam int unsigned T_W = 31;
  localparam logic [T_W-1:0] Q30_ONE = 31'h4000_0000;

  // pi/2 in Q32
  localparam logic [32:0] PI_HALF_Q32 = 33'h1_921F_B544;

  localparam int unsigned PHASE_BITS = 32;
  localparam int unsigned OCT_BITS = 29;
  localparam logic [ANG_W-1:0] OCT_SPAN = 30'h2000_0000;

  localparam int unsigned HORNER_CELLS = 6;
  localparam int unsigned RECIP_SHIFT = 32;

  // normalized operands stay below 2^NORM_BITS before rounding
  localparam int unsigned NORM_BITS = 31;
  localparam int unsigned ROOT_BITS = 32;
  localparam int unsigned REM_W = ROOT_BITS + 2;

  typedef struct packed {
    logic [T_W-1:0]   ts;
    logic [T_W-1:0]   tc;
    logic [ANG_W-1:0] v;
    logic [ANG_W-1:0] v2;
  } horner_t;

  typedef struct packed {
    logic [REM_W-1:0]       rem;
    logic [ROOT_BITS-1:0]   root;
    logic [2*ROOT_BITS-1:0] rad;
  } sqrt_t;

  // sine series divisors, first cell passes the sine term through
  function automatic int unsigned sin_div(input int unsigned idx);
    int unsigned r;
    unique case (idx)
      0: r = 0;
      1: r = 110;
      2: r = 72;
      3: r = 42;
      4: r = 20;
      5: r = 6;
      default: r = 0;
    endcase
    return r;
  endfunction

  function automatic int unsigned cos_div(input int unsigned idx);
    int unsigned r;
    unique case (idx)
      0: r = 132;
      1: r = 90;
      2: r = 56;
      3: r = 30;
      4: r = 12;
      5: r = 2;
      default: r = 2;
    endcase
    return r;
  endfunction

endpackage

@@ hw/rtl/ept_horner_cell.sv @@
// One Horner step of the sine and cosine series, three register stages.
// Depends on ept_pkg.
module ept_horner_cell #(
  parameter int unsigned SIN_DIV = 0,
  parameter int unsigned COS_DIV = 2
) (
  input  logic             clk,
  input  logic             en,
  input  ept_pkg::horner_t d,
  output ept_pkg::horner_t q
);

  localparam int unsigned TW = ept_pkg::T_W;
  localparam int unsigned FB = ept_pkg::FRAC_BITS;
  localparam int unsigned RS = ept_pkg::RECIP_SHIFT;
  localparam int unsigned PW2 = 2 * TW;
  localparam int unsigned MW = TW + 8;
  localparam logic [32:0] SIN_RECIP = 33'((64'd1 << RS) / ((SIN_DIV == 0) ? 1 : SIN_DIV));
  localparam logic [32:0] COS_RECIP = 33'((64'd1 << RS) / ((COS_DIV == 0) ? 1 : COS_DIV));

  ept_pkg::horner_t h1, h2;
  logic [TW-1:0]  xs1, xc1, xs2, xc2, qs2, qc2;
  logic [PW2-1:0] ps, pc;
  logic [63:0]    ms, mc;
  logic [MW-1:0]  rs, rc;
  logic [TW-1:0]  ts_new, tc_new;

  always_comb begin
    ps = PW2'(d.v2) * PW2'(d.ts);
    pc = PW2'(d.v2) * PW2'(d.tc);
    // quotient estimate by reciprocal, at most one short
    ms = 64'(xs1) * 64'(SIN_RECIP);
    mc = 64'(xc1) * 64'(COS_RECIP);
    rs = MW'(xs2) - MW'(qs2) * MW'(SIN_DIV);
    rc = MW'(xc2) - MW'(qc2) * MW'(COS_DIV);
    ts_new = ept_pkg::Q30_ONE - (qs2 + TW'(rs >= MW'(SIN_DIV)));
    tc_new = ept_pkg::Q30_ONE - (qc2 + TW'(rc >= MW'(COS_DIV)));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h1   <= d;
      xs1  <= ps[FB+TW-1:FB];
      xc1  <= pc[FB+TW-1:FB];
      h2   <= h1;
      xs2  <= xs1;
      xc2  <= xc1;
      qs2  <= ms[RS+TW-1:RS];
      qc2  <= mc[RS+TW-1:RS];
      q.v  <= h2.v;
      q.v2 <= h2.v2;
      q.ts <= (SIN_DIV == 0) ? h2.ts : ts_new;
      q.tc <= (COS_DIV == 0) ? h2.tc : tc_new;
    end
  end

endmodule

@@ hw/rtl/ept_sqrt_cell.sv @@
// One root bit of the integer square root, one register stage.
// Depends on ept_pkg.
module ept_sqrt_cell (
  input  logic           clk,
  input  logic           en,
  input  ept_pkg::sqrt_t d,
  output ept_pkg::sqrt_t q
);

  localparam int unsigned RB = ept_pkg::ROOT_BITS;
  localparam int unsigned RW = ept_pkg::REM_W;

  logic [RW+1:0] rem_sh, trial;
  logic          take;

  always_comb begin
    rem_sh = {d.rem, d.rad[2*RB-1:2*RB-2]};
    trial  = (RW + 2)'({d.root, 2'b01});
    take   = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q.rem  <= take ? RW'(rem_sh - trial) : RW'(rem_sh);
      q.root <= {d.root[RB-2:0], take};
      q.rad  <= {d.rad[2*RB-3:0], 2'b00};
    end
  end

endmodule

@@ hw/rtl/ept_div_cell.sv @@
// One quotient bit of a restoring divider, one register stage.
// Remainder and numerator share one shift register; no package use.
module ept_div_cell #(
  parameter int unsigned QUO_BITS = 20
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [QUO_BITS+32:0]  acc_d,
  input  logic [31:0]           den_d,
  output logic [QUO_BITS+32:0]  acc_q,
  output logic [31:0]           den_q
);

  localparam int unsigned AW = QUO_BITS + 33;

  logic [AW-1:0] sh;
  logic [32:0]   top;
  logic          take;

  always_comb begin
    sh   = {acc_d[AW-2:0], 1'b0};
    top  = sh[AW-1:QUO_BITS];
    take = top >= {1'b0, den_d};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc_q <= take ? {top - {1'b0, den_d}, sh[QUO_BITS-1:1], 1'b1} : sh;
      den_q <= den_d;
    end
  end

endmodule

@@ hw/rtl/ellipse_point_at_angle.sv @@
// Ellipse point at a polar angle, fully pipelined over chains of cells.
// Depends on ept_pkg, ept_horner_cell, ept_sqrt_cell and ept_div_cell.
//
// Takes one transaction per cycle while not held and returns one result per
// transaction, in order. Between input acceptance and out_valid lie 3 phase stages,
// 18 in the six series cells, 6 for scaling and squaring, 32 square-root cells, one
// numerator stage, one divider cell per output bit and the output register. The
// pipeline advances as one; it holds only when a finished result waits in the output
// register and another reaches the tail.
// Zero axis length gives (0, 0).
module ellipse_point_at_angle #(
  parameter int unsigned AXIS_BITS = 20,
  parameter int unsigned ANGLE_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [AXIS_BITS-1:0]        major_axis,
  input  logic [AXIS_BITS-1:0]        minor_axis,
  input  logic [ANGLE_BITS-1:0]       angle,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [AXIS_BITS:0]   point_x,
  output logic signed [AXIS_BITS:0]   point_y
);

  localparam int unsigned HC = ept_pkg::HORNER_CELLS;
  localparam int unsigned RB = ept_pkg::ROOT_BITS;
  localparam int unsigned FB = ept_pkg::FRAC_BITS;
  localparam int unsigned TW = ept_pkg::T_W;
  localparam int unsigned VW = ept_pkg::ANG_W;
  localparam int unsigned PH_SHIFT = ept_pkg::PHASE_BITS - ANGLE_BITS;
  localparam int unsigned PW = AXIS_BITS + TW;
  localparam int unsigned PRW = PW + 2;
  localparam int unsigned KW = $clog2(AXIS_BITS + 1);
  localparam int unsigned NW = AXIS_BITS + RB;
  localparam int unsigned AW = NW + 1;
  localparam int unsigned OW = AXIS_BITS + 1;
  localparam int unsigned VPW = 2 * VW;
  localparam int unsigned SPW = VW + TW;

  // stage numbers
  localparam int unsigned H0   = 2;
  localparam int unsigned SC   = H0 + 3 * HC + 1;
  localparam int unsigned PQ   = SC + 1;
  localparam int unsigned KS   = PQ + 1;
  localparam int unsigned PN   = KS + 1;
  localparam int unsigned SQ   = PN + 1;
  localparam int unsigned SUM  = SQ + 1;
  localparam int unsigned NUM  = SUM + RB + 1;
  localparam int unsigned LAST = NUM + AXIS_BITS;

  typedef struct packed {
    logic                 zero;
    logic                 neg_s;
    logic                 neg_c;
    logic                 swap;
    logic [AXIS_BITS-1:0] a;
    logic [AXIS_BITS-1:0] b;
  } side_t;

  logic en;
  logic [LAST:0] vld_q;
  side_t side_q [0:LAST];
  side_t side_d;

  logic [31:0]          phase;
  logic [2:0]           oct;
  logic [VW-1:0]        um, um_q, v_q;
  logic [63:0]          vprod;
  logic [VPW-1:0]       vsq;
  ept_pkg::horner_t     hc0_q;
  ept_pkg::horner_t     hc [0:HC];
  logic [SPW-1:0]       sprod;
  logic [TW-1:0]        s_q, c_q;
  logic [PW-1:0]        p_q, q_q, p2_q, q2_q, por;
  logic [KW-1:0]        k_q, k_next;
  logic [PW:0]          pshift, qshift;
  logic [PRW-1:0]       pr, qr;
  logic [31:0]          pn_q, qn_q;
  logic [63:0]          psq_q, qsq_q;
  logic [63:0]          pnl_q [SQ:NUM-1];
  ept_pkg::sqrt_t       rt0_q;
  ept_pkg::sqrt_t       rt [0:RB];
  logic [NW-1:0]        nx, ny;
  logic [AW-1:0]        accx0_q, accy0_q;
  logic [31:0]          den0_q;
  logic [AW-1:0]        dx [0:AXIS_BITS];
  logic [AW-1:0]        dy [0:AXIS_BITS];
  logic [31:0]          denx [0:AXIS_BITS];
  logic [31:0]          deny [0:AXIS_BITS];
  logic [32:0]          rx, ry;
  logic [OW-1:0]        mx_x, mx_y, px, py;
  logic                 zero_out;

  // hold the whole pipe only when the tail has a result and the output is blocked
  assign en = !(vld_q[LAST] && out_valid && out_stall);
  assign in_stall = !en;

  always_comb begin
    phase = {angle, {PH_SHIFT{1'b0}}};
    oct   = phase[31:29];
    um    = oct[0] ? (ept_pkg::OCT_SPAN - VW'(phase[28:0])) : VW'(phase[28:0]);
    side_d.zero  = (major_axis == '0) || (minor_axis == '0);
    side_d.neg_s = oct[2];
    side_d.neg_c = oct[2] ^ oct[1];
    side_d.swap  = oct[1] ^ oct[0];
    side_d.a     = major_axis;
    side_d.b     = minor_axis;
  end

  always_comb begin
    vprod = 64'(um_q) * 64'(ept_pkg::PI_HALF_Q32) + 64'h8000_0000;
    vsq   = VPW'(v_q) * VPW'(v_q);
    sprod = SPW'(hc[HC].v) * SPW'(hc[HC].ts);
    por   = p_q | q_q;
    k_next = '0;
    for (int i = ept_pkg::NORM_BITS; i < PW; i++) begin
      if (por[i]) begin
        k_next = KW'(i - ept_pkg::NORM_BITS + 1);
      end
    end
    // round half up on the dropped bits
    pshift = {p2_q, 1'b0} >> k_q;
    qshift = {q2_q, 1'b0} >> k_q;
    pr = PRW'(pshift) + PRW'(1);
    qr = PRW'(qshift) + PRW'(1);
    nx = NW'(side_q[NUM-1].a) * NW'(pnl_q[NUM-1][31:0]);
    ny = NW'(side_q[NUM-1].b) * NW'(pnl_q[NUM-1][63:32]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAST-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_q[0] <= side_d;
      for (int i = 1; i <= LAST; i++) begin
        side_q[i] <= side_q[i-1];
      end
      um_q     <= um;
      v_q      <= vprod[61:32];
      hc0_q.ts <= ept_pkg::Q30_ONE;
      hc0_q.tc <= ept_pkg::Q30_ONE;
      hc0_q.v  <= v_q;
      hc0_q.v2 <= vsq[VPW-1:FB];
      s_q      <= side_q[SC-1].swap ? hc[HC].tc : sprod[FB+TW-1:FB];
      c_q      <= side_q[SC-1].swap ? sprod[FB+TW-1:FB] : hc[HC].tc;
      p_q      <= PW'(side_q[PQ-1].a) * PW'(s_q);
      q_q      <= PW'(side_q[PQ-1].b) * PW'(c_q);
      p2_q     <= p_q;
      q2_q     <= q_q;
      k_q      <= k_next;
      pn_q     <= pr[32:1];
      qn_q     <= qr[32:1];
      psq_q    <= 64'(pn_q) * 64'(pn_q);
      qsq_q    <= 64'(qn_q) * 64'(qn_q);
      pnl_q[SQ] <= {pn_q, qn_q};
      for (int i = SQ + 1; i < NUM; i++) begin
        pnl_q[i] <= pnl_q[i-1];
      end
      rt0_q.rem  <= '0;
      rt0_q.root <= '0;
      rt0_q.rad  <= psq_q + qsq_q;
      accx0_q <= {1'b0, nx};
      accy0_q <= {1'b0, ny};
      den0_q  <= rt[RB].root;
    end
  end

  assign hc[0] = hc0_q;
  for (genvar i = 0; i < HC; i++) begin : g_horner
    ept_horner_cell #(
      .SIN_DIV(ept_pkg::sin_div(i)),
      .COS_DIV(ept_pkg::cos_div(i))
    ) u_cell (
      .clk(clk),
      .en (en),
      .d  (hc[i]),
      .q  (hc[i+1])
    );
  end

  assign rt[0] = rt0_q;
  for (genvar i = 0; i < RB; i++) begin : g_sqrt
    ept_sqrt_cell u_cell (
      .clk(clk),
      .en (en),
      .d  (rt[i]),
      .q  (rt[i+1])
    );
  end

  assign dx[0]   = accx0_q;
  assign dy[0]   = accy0_q;
  assign denx[0] = den0_q;
  assign deny[0] = den0_q;
  for (genvar i = 0; i < AXIS_BITS; i++) begin : g_div
    ept_div_cell #(.QUO_BITS(AXIS_BITS)) u_cell_x (
      .clk  (clk),
      .en   (en),
      .acc_d(dx[i]),
      .den_d(denx[i]),
      .acc_q(dx[i+1]),
      .den_q(denx[i+1])
    );
    ept_div_cell #(.QUO_BITS(AXIS_BITS)) u_cell_y (
      .clk  (clk),
      .en   (en),
      .acc_d(dy[i]),
      .den_d(deny[i]),
      .acc_q(dy[i+1]),
      .den_q(deny[i+1])
    );
  end

  // round half away from zero, clamp to the axis, apply the quadrant sign
  always_comb begin
    rx = dx[AXIS_BITS][AW-1:AXIS_BITS];
    ry = dy[AXIS_BITS][AW-1:AXIS_BITS];
    mx_x = OW'(dx[AXIS_BITS][AXIS_BITS-1:0])
         + OW'(rx >= ({1'b0, denx[AXIS_BITS]} - rx));
    mx_y = OW'(dy[AXIS_BITS][AXIS_BITS-1:0])
         + OW'(ry >= ({1'b0, deny[AXIS_BITS]} - ry));
    if (mx_x > OW'(side_q[LAST].a)) begin
      mx_x = OW'(side_q[LAST].a);
    end
    if (mx_y > OW'(side_q[LAST].b)) begin
      mx_y = OW'(side_q[LAST].b);
    end
    zero_out = side_q[LAST].zero || (denx[AXIS_BITS] == '0);
    px = side_q[LAST].neg_c ? (OW'(0) - mx_x) : mx_x;
    py = side_q[LAST].neg_s ? (OW'(0) - mx_y) : mx_y;
    if (zero_out) begin
      px = '0;
      py = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en && vld_q[LAST]) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && vld_q[LAST]) begin
      point_x <= px;
      point_y <= py;
    end
  end

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> vld_q[0])
    else $error("accepted transaction did not enter the pipeline");

  a_out_from_tail: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(vld_q[LAST]))
    else $error("output loaded without a result at the tail");

  a_norm_bound: assert property (@(posedge clk) disable iff (rst)
    vld_q[PN] |-> (pn_q <= 32'h8000_0000 && qn_q <= 32'h8000_0000))
    else $error("normalized operand out of range");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    vld_q[LAST] |-> (denx[AXIS_BITS] == '0
      || (rx < {1'b0, denx[AXIS_BITS]} && ry < {1'b0, deny[AXIS_BITS]})))
    else $error("divider remainder not below the root");

endmodule
